// ===== rtl/core/shb_pkg.sv =====
package shb_pkg;

  localparam int HashWidth   = 49;
  localparam int CharWidth   = 7;
  localparam int BucketWidth = 16;
  localparam int ModeWidth   = 2;

  // remainder unit retires DivRadix dividend bits per cycle
  localparam int DivRadix    = 4;
  localparam int DivSteps    = (HashWidth + DivRadix - 1) / DivRadix;
  localparam int DvdWidth    = DivSteps * DivRadix;
  localparam int DivCntWidth = $clog2(DivSteps);

  typedef enum logic [ModeWidth-1:0] {
    MODE_PRODUCT = 2'd0,
    MODE_SHIFT4  = 2'd1,
    MODE_MUL613  = 2'd2
  } hash_mode_e;

  typedef enum logic {
    REG_HASH_MODE  = 1'b0,
    REG_TABLE_SIZE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_END,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [BucketWidth-1:0] bucket;
    logic [HashWidth-1:0]   hash_value;
    logic                   key_too_long;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic reduce;
    logic fold;
    logic mark_ovf;
    logic div_start;
    logic div_step;
    logic load;
  } shb_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic ovf;
    logic div_done;
    logic out_free;
  } shb_sts_t;

  function automatic logic [HashWidth-1:0] mode_seed(input logic [ModeWidth-1:0] mode);
    logic [HashWidth-1:0] seed;
    case (hash_mode_e'(mode))
      MODE_SHIFT4: seed = HashWidth'(0);
      MODE_MUL613: seed = HashWidth'(5);
      default:     seed = HashWidth'(1);
    endcase
    return seed;
  endfunction

  // 256 = -1 mod 257, so alternate byte signs, then one reciprocal step
  function automatic logic [8:0] mod257(input logic [HashWidth-1:0] v);
    logic [10:0] pos;
    logic [10:0] neg;
    logic [11:0] s;
    logic [19:0] prod;
    logic [2:0]  q;
    logic [11:0] r;
    pos  = 11'(v[7:0]) + 11'(v[23:16]) + 11'(v[39:32]) + 11'(v[48]);
    neg  = 11'(v[15:8]) + 11'(v[31:24]) + 11'(v[47:40]);
    s    = 12'(pos) + 12'd771 - 12'(neg);
    prod = 20'(s) * 20'd255;
    q    = prod[18:16];
    r    = s - 12'(12'(q) * 12'd257);
    if (r >= 12'd257) begin
      r = r - 12'd257;
    end
    return r[8:0];
  endfunction

endpackage

// ===== rtl/core/shb_ctrl.sv =====
module shb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  shb_pkg::shb_sts_t sts_i,
  output shb_pkg::shb_cmd_t cmd_o
);
  import shb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        state_d = sts_i.full ? ST_END : ST_FOLD;
      end
      ST_FOLD: begin
        state_d = ST_END;
      end
      ST_END: begin
        if (!sts_i.last) begin
          state_d = ST_IDLE;
        end else if (sts_i.ovf) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_REDUCE: begin
        cmd_o.mark_ovf = sts_i.full;
        cmd_o.reduce   = !sts_i.full;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
      end
      ST_END: begin
        cmd_o.div_start = sts_i.last && !sts_i.ovf;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/shb_dp.sv =====
module shb_dp #(
  parameter int MAX_KEY_LEN = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [shb_pkg::ModeWidth-1:0]       hash_mode_i,
  input  logic [shb_pkg::BucketWidth-1:0]     table_size_i,
  input  shb_pkg::in_item_t                   in_data_i,
  input  shb_pkg::shb_cmd_t                   cmd_i,
  output shb_pkg::shb_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output shb_pkg::out_item_t                  out_data_o
);
  import shb_pkg::*;

  localparam int CntWidth = $clog2(MAX_KEY_LEN + 1);

  logic [CharWidth-1:0]   char_q;
  logic                   last_q;
  logic [HashWidth-1:0]   hash_q, hash_d;
  logic [8:0]             r257_q;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [BucketWidth-1:0] rem_q, rem_d;
  logic [DvdWidth-1:0]    dvd_q, dvd_d;
  logic [DivCntWidth-1:0] div_cnt_q, div_cnt_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic [HashWidth-1:0]   base;
  logic [BucketWidth:0]   trial;

  assign base = (cnt_q == '0) ? mode_seed(hash_mode_i) : hash_q;

  always_comb begin
    hash_d = hash_q;
    case (hash_mode_e'(hash_mode_i))
      MODE_SHIFT4: hash_d = (base << 2) + HashWidth'(char_q);
      MODE_MUL613: hash_d = (base * HashWidth'(613)) + HashWidth'(char_q);
      default:     hash_d = HashWidth'(16'(char_q) * 16'(r257_q + 9'd1));
    endcase
  end

  // radix-16 restoring remainder, one dividend bit per inner step
  always_comb begin
    trial = '0;
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      dvd_d = DvdWidth'(hash_q);
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < DivRadix; i++) begin
        trial = {rem_d, dvd_d[DvdWidth-1]};
        dvd_d = dvd_d << 1;
        if (trial >= {1'b0, table_size_i}) begin
          rem_d = BucketWidth'(trial - {1'b0, table_size_i});
        end else begin
          rem_d = trial[BucketWidth-1:0];
        end
      end
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.fold) begin
      cnt_d = cnt_q + CntWidth'(1);
    end
    if (cmd_i.mark_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.div_start) begin
      div_cnt_d = '0;
    end else if (cmd_i.div_step) begin
      div_cnt_d = div_cnt_q + DivCntWidth'(1);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      cnt_d              = '0;
      ovf_d              = 1'b0;
      out_valid_d        = 1'b1;
      out_d.key_too_long = ovf_q;
      out_d.hash_value   = ovf_q ? '0 : hash_q;
      out_d.bucket       = (ovf_q || table_size_i == '0) ? '0 : rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      char_q <= in_data_i.char_code;
      last_q <= in_data_i.last;
    end
    if (cmd_i.reduce) begin
      r257_q <= mod257(base);
    end
    if (cmd_i.fold) begin
      hash_q <= hash_d;
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    out_q <= out_d;
  end

  assign sts_o.full     = cnt_q >= CntWidth'(MAX_KEY_LEN);
  assign sts_o.last     = last_q;
  assign sts_o.ovf      = ovf_q;
  assign sts_o.div_done = div_cnt_q == DivCntWidth'(DivSteps - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(MAX_KEY_LEN))
    else $error("character count past key limit");

  a_r257_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reduce |=> r257_q < 9'd257)
    else $error("mod 257 residue out of range");

  a_key_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (cnt_q == '0 && !ovf_q && out_valid_q))
    else $error("key state not cleared after result");

endmodule

// ===== rtl/core/string_hash_to_bucket.sv =====
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   in_data_i  (char_code, last)
// out      out  out_valid_o / out_ready_i out_data_o (bucket, hash_value, key_too_long)
// cfg      in   psel penable pwrite pready paddr pwdata / prdata
// a non-closing character passes through capture, mod 257, fold, end check
// a character past the key limit is not folded
// a closing character adds a run of the 4-bit-per-cycle remainder unit and a load
// an over-long key skips the remainder unit
// a waiting result stalls only the next closing character in its load cycle
// reset clears the key state and loads hash_mode 0, table_size 1024
module string_hash_to_bucket #(
  parameter int MAX_KEY_LEN = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shb_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import shb_pkg::*;

  logic [ModeWidth-1:0]   hash_mode_q;
  logic [BucketWidth-1:0] table_size_q;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;
  shb_cmd_t               cmd;
  shb_sts_t               sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q  <= ModeWidth'(MODE_PRODUCT);
      table_size_q <= BucketWidth'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_HASH_MODE:  hash_mode_q  <= pwdata[ModeWidth-1:0];
        REG_TABLE_SIZE: table_size_q <= pwdata[BucketWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_HASH_MODE:  prdata = 32'(hash_mode_q);
      REG_TABLE_SIZE: prdata = 32'(table_size_q);
      default:        prdata = '0;
    endcase
  end

  shb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shb_dp #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hash_mode_i  (hash_mode_q),
    .table_size_i (table_size_q),
    .in_data_i    (in_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
